// ----- hw/rtl/rwm_pkg.sv -----
`timescale 1ns / 1ps
package rwm_pkg;

	localparam int PIX_W   = 8;
	localparam int FIELD_W = 24;
	localparam int ROW_W   = 16;
	localparam int CFG_W   = 16;
	localparam int IDX_W   = 2;
	localparam int FW_W    = 11;
	localparam int RAD_W   = 2;

	typedef enum logic [IDX_W-1:0] {
		REG_RADIUS = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2,
		REG_NONE   = 2'd3
	} reg_idx_t;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_CHECK = 8'b0000_0010,
		ST_MINIT = 8'b0000_0100,
		ST_MRUN  = 8'b0000_1000,
		ST_MWAIT = 8'b0001_0000,
		ST_MDEC  = 8'b0010_0000,
		ST_MDONE = 8'b0100_0000,
		ST_SEND  = 8'b1000_0000
	} state_t;

	// control from the window walker to the per-channel selectors
	typedef struct packed {
		logic       clr;
		logic       smp_v;
		logic       dec;
		logic       first;
		logic [2:0] bit_idx;
	} sel_ctl_t;

endpackage

// ----- hw/rtl/rwm_if.sv -----
`timescale 1ns / 1ps
interface rwm_pix_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] in_red;
	logic [7:0] in_green;
	logic [7:0] in_blue;
	modport source (output valid, kind, in_red, in_green, in_blue, input ready);
	modport sink (input valid, kind, in_red, in_green, in_blue, output ready);
endinterface

interface rwm_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic       last_in_run;
	logic       frame_end;
	modport source (output valid, out_red, out_green, out_blue, last_in_run, frame_end,
		input ready);
	modport sink (input valid, out_red, out_green, out_blue, last_in_run, frame_end,
		output ready);
endinterface

// ----- hw/rtl/rwm_sel.sv -----
`timescale 1ns / 1ps
// radix select of element tot/2, one bit of the result per pass over the window
module rwm_sel #(
	parameter int CNT_W = 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rwm_pkg::sel_ctl_t            ctl,
	input  logic [rwm_pkg::PIX_W-1:0]    smp,
	output logic [rwm_pkg::PIX_W-1:0]    med
);

	logic [CNT_W-1:0]          cnt_q, tot_q, k_q, kk;
	logic [rwm_pkg::PIX_W-1:0] pfx_q, hi_mask;
	logic [rwm_pkg::PIX_W:0]   wide_mask;
	logic                      hit;

	always_comb begin
		wide_mask = {(rwm_pkg::PIX_W+1){1'b1}} << ({1'b0, ctl.bit_idx} + 4'd1);
		hi_mask   = wide_mask[rwm_pkg::PIX_W-1:0];
		hit       = (((smp ^ pfx_q) & hi_mask) == '0) && !smp[ctl.bit_idx];
		kk        = ctl.first ? (tot_q >> 1) : k_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			tot_q <= '0;
			k_q   <= '0;
			pfx_q <= '0;
		end else if (ctl.clr) begin
			cnt_q <= '0;
			tot_q <= '0;
			pfx_q <= '0;
		end else if (ctl.dec) begin
			cnt_q <= '0;
			if (cnt_q > kk) begin
				k_q <= kk;
			end else begin
				k_q <= kk - cnt_q;
				pfx_q[ctl.bit_idx] <= 1'b1;
			end
		end else if (ctl.smp_v) begin
			if (hit) cnt_q <= cnt_q + 1'b1;
			if (ctl.first) tot_q <= tot_q + 1'b1;
		end
	end

	assign med = pfx_q;

endmodule

// ----- hw/rtl/rgb_window_median_filter.sv -----
`timescale 1ns / 1ps
// Streaming RGB median filter over a square window of radius 1..3, clipped at the
// image borders. The last STORE_ROWS rows sit in a line store with one write port
// and one read port. Each output pixel is found bit by bit, MSB first: eight
// passes read the n window samples (n up to 49) one per line-store read. A new
// item is taken only while idle, once every result the last one released has been
// handed to the output register; a hand-over waits while the receiver still holds
// that register. Writing any of the listed registers restarts the frame; do so
// only while the block is idle.
module rgb_window_median_filter #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_RADIUS = 3,
	parameter int STORE_ROWS = 7
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [rwm_pkg::IDX_W-1:0]    cfg_index,
	input  logic [rwm_pkg::CFG_W-1:0]    cfg_data,
	rwm_pix_if.sink                      pix,
	rwm_res_if.source                    res
);

	localparam int RAD_LIM = (MAX_RADIUS < (STORE_ROWS - 1) / 2) ? MAX_RADIUS
		: ((STORE_ROWS - 1) / 2 < 1 ? 1 : (STORE_ROWS - 1) / 2);
	localparam int WIN_MAX = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
	localparam int CNT_W   = $clog2(WIN_MAX + 1);
	localparam int CW      = $clog2(MAX_WIDTH + 1);
	localparam int EW      = CW > rwm_pkg::FW_W ? CW : rwm_pkg::FW_W;
	localparam int DEPTH   = STORE_ROWS * MAX_WIDTH;
	localparam int AW      = $clog2(DEPTH);
	localparam int RMW     = $clog2(STORE_ROWS);
	localparam int RW      = rwm_pkg::ROW_W;
	localparam int NW      = $clog2(RAD_LIM + 2);

	rwm_pkg::state_t state_q;

	logic [rwm_pkg::RAD_W-1:0] rad_reg_q;
	logic [rwm_pkg::FW_W-1:0]  wid_reg_q;
	logic [RW-1:0]             hgt_reg_q;

	logic [RW-1:0]  in_row_q, out_row_q;
	logic [CW-1:0]  in_col_q, out_col_q;
	logic [RMW-1:0] in_mod_q, out_mod_q;
	logic [NW-1:0]  n_q;

	logic [RW-1:0]  ri_q, r0_q, r1_q;
	logic [RMW-1:0] rm_q, r0m_q;
	logic [CW-1:0]  cj_q, c0_q, c1_q;
	logic [2:0]     bit_q;
	logic           rd_v_s1;
	logic [rwm_pkg::FIELD_W-1:0] rd_s1;

	logic [rwm_pkg::FIELD_W-1:0] mem_q [DEPTH];

	logic [rwm_pkg::FIELD_W-1:0] pend_q;
	logic                        pend_v_q, pend_fe_q, snd_last_q;

	logic [rwm_pkg::FIELD_W-1:0] ores_q;
	logic                        ov_q, olast_q, ofe_q;

	// effective configuration
	logic [RW-1:0]   rad, h, hm1, qr, r0c, r1c, dr;
	logic [CW-1:0]   w, wm1, qc, c0c, c1c;
	logic [EW-1:0]   wide_w;
	logic [RW:0]     row_plus;
	logic [CW:0]     col_plus;
	logic [RMW-1:0]  r0m_c;
	logic            more, arrived, wr_en;
	logic [AW-1:0]   rd_addr, wr_addr;
	rwm_pkg::sel_ctl_t ctl;
	logic [rwm_pkg::PIX_W-1:0] med_r, med_g, med_b;

	always_comb begin
		rad = RW'(rad_reg_q);
		if (rad_reg_q == '0) rad = RW'(1);
		if (rad > RW'(RAD_LIM)) rad = RW'(RAD_LIM);
		wide_w = EW'(wid_reg_q);
		if (wide_w == '0) wide_w = EW'(1);
		if (wide_w > EW'(MAX_WIDTH)) wide_w = EW'(MAX_WIDTH);
		w   = wide_w[CW-1:0];
		wm1 = w - 1'b1;
		h   = (hgt_reg_q == '0) ? RW'(1) : hgt_reg_q;
		hm1 = h - 1'b1;

		row_plus = {1'b0, out_row_q} + {1'b0, rad};
		col_plus = {1'b0, out_col_q} + (CW+1)'(rad);
		qr = (row_plus > {1'b0, hm1}) ? hm1 : row_plus[RW-1:0];
		qc = (col_plus > {1'b0, wm1}) ? wm1 : col_plus[CW-1:0];
		r1c = qr;
		c1c = qc;
		r0c = (out_row_q >= rad) ? out_row_q - rad : '0;
		c0c = (CW'(out_col_q) >= CW'(rad)) ? out_col_q - CW'(rad) : '0;
		dr  = out_row_q - r0c;
		r0m_c = (RW'(out_mod_q) >= dr) ? out_mod_q - RMW'(dr)
			: RMW'(RW'(out_mod_q) + RW'(STORE_ROWS) - dr);

		arrived = (in_row_q > qr) || (in_row_q == qr && in_col_q > qc);
		more = (RW'(n_q) < rad + 1'b1) && (out_row_q < h) && (out_col_q < w) && arrived;

		wr_en = (state_q == rwm_pkg::ST_IDLE) && pix.valid && !pix.kind
			&& (in_row_q < h) && (in_col_q < w);
		wr_addr = AW'(in_mod_q) * AW'(MAX_WIDTH) + AW'(in_col_q);
		rd_addr = AW'(rm_q) * AW'(MAX_WIDTH) + AW'(cj_q);

		ctl.clr     = (state_q == rwm_pkg::ST_MINIT);
		ctl.smp_v   = rd_v_s1;
		ctl.dec     = (state_q == rwm_pkg::ST_MDEC);
		ctl.first   = (bit_q == 3'd7);
		ctl.bit_idx = bit_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= {pix.in_red, pix.in_green, pix.in_blue};
		rd_s1 <= mem_q[rd_addr];
	end

	rwm_sel #(.CNT_W(CNT_W)) u_sel_r (.clk, .arst_n, .ctl, .smp(rd_s1[23:16]), .med(med_r));
	rwm_sel #(.CNT_W(CNT_W)) u_sel_g (.clk, .arst_n, .ctl, .smp(rd_s1[15:8]),  .med(med_g));
	rwm_sel #(.CNT_W(CNT_W)) u_sel_b (.clk, .arst_n, .ctl, .smp(rd_s1[7:0]),   .med(med_b));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= rwm_pkg::ST_IDLE;
			rad_reg_q  <= rwm_pkg::RAD_W'(1);
			wid_reg_q  <= rwm_pkg::FW_W'(1024);
			hgt_reg_q  <= RW'(1024);
			in_row_q   <= '0;
			in_col_q   <= '0;
			in_mod_q   <= '0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			out_mod_q  <= '0;
			n_q        <= '0;
			rd_v_s1    <= 1'b0;
			pend_v_q   <= 1'b0;
			snd_last_q <= 1'b0;
			ov_q       <= 1'b0;
			bit_q      <= 3'd7;
		end else begin
			rd_v_s1 <= 1'b0;
			if (ov_q && res.ready) ov_q <= 1'b0;

			if (cfg_we) begin
				unique case (rwm_pkg::reg_idx_t'(cfg_index))
					rwm_pkg::REG_RADIUS: rad_reg_q <= cfg_data[rwm_pkg::RAD_W-1:0];
					rwm_pkg::REG_WIDTH:  wid_reg_q <= cfg_data[rwm_pkg::FW_W-1:0];
					rwm_pkg::REG_HEIGHT: hgt_reg_q <= cfg_data[RW-1:0];
					default: ;
				endcase
				if (rwm_pkg::reg_idx_t'(cfg_index) != rwm_pkg::REG_NONE) begin
					in_row_q  <= '0;
					in_col_q  <= '0;
					in_mod_q  <= '0;
					out_row_q <= '0;
					out_col_q <= '0;
					out_mod_q <= '0;
				end
			end

			unique case (state_q)
				rwm_pkg::ST_IDLE: begin
					if (pix.valid) begin
						if (wr_en) begin
							if (in_col_q + 1'b1 >= w) begin
								in_col_q <= '0;
								in_row_q <= in_row_q + 1'b1;
								in_mod_q <= (in_mod_q == RMW'(STORE_ROWS - 1)) ? '0
									: in_mod_q + 1'b1;
							end else begin
								in_col_q <= in_col_q + 1'b1;
							end
						end
						n_q     <= '0;
						state_q <= rwm_pkg::ST_CHECK;
					end
				end
				rwm_pkg::ST_CHECK: begin
					if (more) begin
						snd_last_q <= 1'b0;
						state_q    <= pend_v_q ? rwm_pkg::ST_SEND : rwm_pkg::ST_MINIT;
					end else begin
						snd_last_q <= 1'b1;
						state_q    <= pend_v_q ? rwm_pkg::ST_SEND : rwm_pkg::ST_IDLE;
						if (in_row_q >= h && out_row_q >= h) begin
							in_row_q  <= '0;
							in_col_q  <= '0;
							in_mod_q  <= '0;
							out_row_q <= '0;
							out_col_q <= '0;
							out_mod_q <= '0;
						end
					end
				end
				rwm_pkg::ST_MINIT: begin
					r0_q    <= r0c;
					r1_q    <= r1c;
					c0_q    <= c0c;
					c1_q    <= c1c;
					r0m_q   <= r0m_c;
					ri_q    <= r0c;
					rm_q    <= r0m_c;
					cj_q    <= c0c;
					bit_q   <= 3'd7;
					state_q <= rwm_pkg::ST_MRUN;
				end
				rwm_pkg::ST_MRUN: begin
					rd_v_s1 <= 1'b1;
					if (cj_q == c1_q) begin
						cj_q <= c0_q;
						if (ri_q == r1_q) begin
							state_q <= rwm_pkg::ST_MWAIT;
						end else begin
							ri_q <= ri_q + 1'b1;
							rm_q <= (rm_q == RMW'(STORE_ROWS - 1)) ? '0 : rm_q + 1'b1;
						end
					end else begin
						cj_q <= cj_q + 1'b1;
					end
				end
				rwm_pkg::ST_MWAIT: state_q <= rwm_pkg::ST_MDEC;
				rwm_pkg::ST_MDEC: begin
					ri_q <= r0_q;
					rm_q <= r0m_q;
					cj_q <= c0_q;
					if (bit_q == 3'd0) begin
						state_q <= rwm_pkg::ST_MDONE;
					end else begin
						bit_q   <= bit_q - 1'b1;
						state_q <= rwm_pkg::ST_MRUN;
					end
				end
				rwm_pkg::ST_MDONE: begin
					pend_q    <= {med_r, med_g, med_b};
					pend_fe_q <= (out_row_q == hm1) && (out_col_q == wm1);
					pend_v_q  <= 1'b1;
					n_q       <= n_q + 1'b1;
					if (out_col_q + 1'b1 >= w) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + 1'b1;
						out_mod_q <= (out_mod_q == RMW'(STORE_ROWS - 1)) ? '0
							: out_mod_q + 1'b1;
					end else begin
						out_col_q <= out_col_q + 1'b1;
					end
					state_q <= rwm_pkg::ST_CHECK;
				end
				rwm_pkg::ST_SEND: begin
					if (!ov_q || res.ready) begin
						ov_q     <= 1'b1;
						ores_q   <= pend_q;
						olast_q  <= snd_last_q;
						ofe_q    <= pend_fe_q;
						pend_v_q <= 1'b0;
						state_q  <= snd_last_q ? rwm_pkg::ST_IDLE : rwm_pkg::ST_MINIT;
					end
				end
				default: state_q <= rwm_pkg::ST_IDLE;
			endcase
		end
	end

	assign pix.ready       = (state_q == rwm_pkg::ST_IDLE);
	assign res.valid       = ov_q;
	assign res.out_red     = ores_q[23:16];
	assign res.out_green   = ores_q[15:8];
	assign res.out_blue    = ores_q[7:0];
	assign res.last_in_run = olast_q;
	assign res.frame_end   = ofe_q;

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

	localparam int MAX_W    = 1024;
	localparam int MAX_R    = 3;
	localparam int ROWS     = 7;
	localparam int SETTLE   = 600;
	localparam int HOLD_LEN = 900;
	localparam int WIN_N    = 49;

	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last_in_run;
		logic       frame_end;
	} median_px_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [rwm_pkg::IDX_W-1:0] cfg_index;
	logic [rwm_pkg::CFG_W-1:0] cfg_data;

	rwm_pix_if pix ();
	rwm_res_if res ();

	rgb_window_median_filter dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pix(pix.sink),
		.res(res.source)
	);

	// shadow of the block: line store, raster counters, registers
	logic [23:0] shadow_rows [0:ROWS*MAX_W-1];
	int unsigned in_row, in_col, out_row, out_col;
	logic [rwm_pkg::RAD_W-1:0] radius_reg;
	logic [rwm_pkg::FW_W-1:0] width_reg;
	logic [15:0] height_reg;

	median_px_t pending_medians[$];
	int errors = 0;
	int items_sent = 0;
	bit no_idle = 0;
	int hold_requests = 0;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int unsigned eff_rad();
		int unsigned r;
		r = radius_reg;
		if (r < 1) r = 1;
		if (r > MAX_R) r = MAX_R;
		return r;
	endfunction

	function automatic int unsigned eff_w();
		int unsigned w;
		w = width_reg;
		if (w < 1) w = 1;
		if (w > MAX_W) w = MAX_W;
		return w;
	endfunction

	function automatic int unsigned eff_h();
		return (height_reg == 0) ? 1 : height_reg;
	endfunction

	function automatic int unsigned row_addr(int unsigned row, int unsigned col);
		return (row % ROWS) * MAX_W + col;
	endfunction

	function automatic logic [7:0] middle_of(logic [7:0] v[WIN_N], int n);
		logic [7:0] t;
		int j;
		for (int i = 1; i < n; i++) begin
			t = v[i];
			j = i;
			while (j > 0 && v[j-1] > t) begin
				v[j] = v[j-1];
				j--;
			end
			v[j] = t;
		end
		return v[n/2];
	endfunction

	function automatic median_px_t window_median(int unsigned r, int unsigned c,
			int unsigned rad, int unsigned w, int unsigned h);
		logic [7:0] rs[WIN_N];
		logic [7:0] gs[WIN_N];
		logic [7:0] bs[WIN_N];
		median_px_t m;
		int unsigned r0, r1, c0, c1;
		int n;
		logic [23:0] px;
		n = 0;
		r0 = (r >= rad) ? r - rad : 0;
		c0 = (c >= rad) ? c - rad : 0;
		r1 = (r + rad > h - 1) ? h - 1 : r + rad;
		c1 = (c + rad > w - 1) ? w - 1 : c + rad;
		for (int unsigned i = r0; i <= r1; i++) begin
			for (int unsigned j = c0; j <= c1; j++) begin
				px = shadow_rows[row_addr(i, j)];
				rs[n] = px[23:16];
				gs[n] = px[15:8];
				bs[n] = px[7:0];
				n++;
			end
		end
		m.red = middle_of(rs, n);
		m.green = middle_of(gs, n);
		m.blue = middle_of(bs, n);
		m.last_in_run = 1'b0;
		m.frame_end = 1'b0;
		return m;
	endfunction

	function automatic void predict_medians(logic kind, logic [7:0] r, logic [7:0] g,
			logic [7:0] b);
		int unsigned rad, w, h, qr, qc, n;
		median_px_t m;
		rad = eff_rad();
		w = eff_w();
		h = eff_h();
		n = 0;
		if (!kind && in_row < h && in_col < w) begin
			shadow_rows[row_addr(in_row, in_col)] = {r, g, b};
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
			end
		end
		while (n < rad + 1 && out_row < h && out_col < w) begin
			qr = (out_row + rad > h - 1) ? h - 1 : out_row + rad;
			qc = (out_col + rad > w - 1) ? w - 1 : out_col + rad;
			if (!(in_row > qr || (in_row == qr && in_col > qc))) break;
			m = window_median(out_row, out_col, rad, w, h);
			m.frame_end = (out_row == h - 1 && out_col == w - 1);
			pending_medians.push_back(m);
			n++;
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				out_row++;
			end
		end
		if (n > 0) pending_medians[$].last_in_run = 1'b1;
		if (in_row >= h && out_row >= h) begin
			in_row = 0; in_col = 0; out_row = 0; out_col = 0;
		end
	endfunction

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 13);
	endfunction

	// receiver: random gaps, plus a long hold when a test asks for one
	int rx_gap = 0;
	int rx_hold = 0;
	int holds_seen = 0;
	always @(posedge clk) begin
		median_px_t e;
		if (arst_n) begin
			if (res.valid && res.ready) begin
				if (pending_medians.size() == 0) begin
					$display("%0t: result with none expected, got %h %h %h", $realtime,
						res.out_red, res.out_green, res.out_blue);
					errors++;
				end else begin
					e = pending_medians.pop_front();
					if (res.out_red !== e.red) begin
						$display("%0t: out_red exp %h got %h", $realtime, e.red, res.out_red);
						errors++;
					end
					if (res.out_green !== e.green) begin
						$display("%0t: out_green exp %h got %h", $realtime, e.green,
							res.out_green);
						errors++;
					end
					if (res.out_blue !== e.blue) begin
						$display("%0t: out_blue exp %h got %h", $realtime, e.blue, res.out_blue);
						errors++;
					end
					if (res.last_in_run !== e.last_in_run) begin
						$display("%0t: last_in_run exp %b got %b", $realtime, e.last_in_run,
							res.last_in_run);
						errors++;
					end
					if (res.frame_end !== e.frame_end) begin
						$display("%0t: frame_end exp %b got %b", $realtime, e.frame_end,
							res.frame_end);
						errors++;
					end
				end
				rx_gap = draw_gap();
			end
			if (holds_seen != hold_requests) begin
				holds_seen = hold_requests;
				rx_hold = HOLD_LEN;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				res.ready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	task automatic send_item(logic kind, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			pix.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix.valid <= 1'b1;
		pix.kind <= kind;
		pix.in_red <= r;
		pix.in_green <= g;
		pix.in_blue <= b;
		forever begin
			@(posedge clk);
			if (pix.ready) break;
		end
		predict_medians(kind, r, g, b);
		items_sent++;
	endtask

	task automatic send_random_pixel();
		send_item(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
	endtask

	task automatic send_drain();
		send_item(1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
	endtask

	task automatic wait_drained();
		pix.valid <= 1'b0;
		while (pending_medians.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(rwm_pkg::reg_idx_t idx, logic [rwm_pkg::CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			rwm_pkg::REG_RADIUS: radius_reg = value[rwm_pkg::RAD_W-1:0];
			rwm_pkg::REG_WIDTH: width_reg = value[rwm_pkg::FW_W-1:0];
			rwm_pkg::REG_HEIGHT: height_reg = value;
			default: ;
		endcase
		if (idx != rwm_pkg::REG_NONE) begin
			in_row = 0; in_col = 0; out_row = 0; out_col = 0;
		end
	endtask

	task automatic setup_frame(int rad, int w, int h);
		write_reg(rwm_pkg::REG_RADIUS, rwm_pkg::CFG_W'(rad));
		write_reg(rwm_pkg::REG_WIDTH, rwm_pkg::CFG_W'(w));
		write_reg(rwm_pkg::REG_HEIGHT, rwm_pkg::CFG_W'(h));
	endtask

	// drain ticks until the frame wraps back to its start
	task automatic flush_frame();
		int guard;
		guard = 0;
		while (in_row >= eff_h() && guard < 40) begin
			if ($urandom_range(0, 5) == 0) send_random_pixel();
			else send_drain();
			guard++;
		end
	endtask

	task automatic run_frame(int npix_limit);
		int total;
		total = eff_w() * eff_h();
		if (total > npix_limit) total = npix_limit;
		for (int i = 0; i < total; i++) begin
			if ($urandom_range(0, 9) == 0) send_drain();
			send_random_pixel();
		end
		flush_frame();
	endtask

	task automatic test_directed();
		// reset settings: a 1024 wide frame gives nothing yet
		send_item(1'b0, 8'h00, 8'h00, 8'h00);
		send_item(1'b0, 8'hff, 8'hff, 8'hff);
		send_item(1'b1, 8'hff, 8'hff, 8'hff);
		wait_drained();
		// radius zero acts as one, single pixel frame
		setup_frame(0, 1, 1);
		send_item(1'b0, 8'hff, 8'h00, 8'haa);
		send_item(1'b0, 8'h55, 8'h0f, 8'hf0);
		wait_drained();
		// zero height acts as one, radius wider than the image
		setup_frame(3, 2, 0);
		send_item(1'b0, 8'h00, 8'hff, 8'h01);
		send_item(1'b0, 8'hff, 8'h00, 8'h80);
		wait_drained();
		// zero width acts as one
		setup_frame(2, 0, 3);
		for (int i = 0; i < 3; i++) send_item(1'b0, 8'(i * 127), 8'(255 - i * 127), 8'h7f);
		flush_frame();
		wait_drained();
		// clipped 3x3 frame of extremes, drain tick before the end
		setup_frame(3, 3, 3);
		for (int i = 0; i < 9; i++) begin
			if (i == 4) send_drain();
			send_item(1'b0, (i % 2) ? 8'hff : 8'h00, (i % 3) ? 8'h00 : 8'hff, 8'(i * 31));
		end
		flush_frame();
		wait_drained();
		// oversized width and full height: stores only, then unlisted index
		setup_frame(2, 16'h07ff, 16'hffff);
		send_random_pixel();
		send_random_pixel();
		wait_drained();
		write_reg(rwm_pkg::REG_NONE, 16'hffff);
		send_random_pixel();
		wait_drained();
	endtask

	task automatic test_back_pressure();
		setup_frame(1, 6, 5);
		hold_requests++;
		no_idle = 1;
		run_frame(1000);
		no_idle = 0;
		wait_drained();
	endtask

	task automatic test_random_frames();
		int rad, w, h;
		while (items_sent < 380) begin
			rad = $urandom_range(0, 3);
			if ($urandom_range(0, 7) == 0) begin
				w = $urandom_range(7, 12);
				h = $urandom_range(7, 9);
			end else begin
				w = $urandom_range(1, 8);
				h = $urandom_range(1, 6);
			end
			setup_frame(rad, w, h);
			no_idle = ($urandom_range(0, 4) == 0);
			// now and then cut a frame short and restart it
			if ($urandom_range(0, 9) == 0) run_frame($urandom_range(1, w * h));
			else run_frame(1000);
			no_idle = 0;
			wait_drained();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = rwm_pkg::REG_RADIUS;
		cfg_data = '0;
		pix.valid = 1'b0;
		pix.kind = 1'b0;
		pix.in_red = '0;
		pix.in_green = '0;
		pix.in_blue = '0;
		res.ready = 1'b0;
		radius_reg = 1;
		width_reg = 1024;
		height_reg = 1024;
		in_row = 0; in_col = 0; out_row = 0; out_col = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_back_pressure();
		test_random_frames();
		wait_drained();
		if (errors == 0) $display("end of test: clean");
		else $display("end of test: mismatches");
		$finish;
	end

	initial begin
		#80_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/rwm_pkg.sv
hw/rtl/rwm_if.sv
hw/rtl/rwm_sel.sv
hw/rtl/rgb_window_median_filter.sv
verif/testbench.sv
